// ===== sv/spt_pkg.sv =====
// Shared types and constants for the semiprime trial-division block.
package spt_pkg;

	localparam int SMALL_W     = 16;
	localparam int LARGE_W     = 30;
	localparam int OUT_TDATA_W = 48;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	// position on the candidate wheel: 2, 3, then 6k-1 / 6k+1
	typedef enum logic [1:0] {
		WH_TWO   = 2'd0,
		WH_THREE = 2'd1,
		WH_P2    = 2'd2,
		WH_P4    = 2'd3
	} wheel_t;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} div_status_t;

endpackage

// ===== sv/spt_serial_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module spt_serial_div #(
	parameter int NW = 31,
	parameter int DW = 17
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [NW-1:0]             dividend,
	input  logic [DW-1:0]             divisor,
	output spt_pkg::div_status_t      status,
	output logic [NW-1:0]             quotient
);
	import spt_pkg::*;

	localparam int CW = $clog2(NW);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DW-1:0]     div_q;
	// {remainder, dividend bits shifting out / quotient bits shifting in}
	logic [DW+NW-1:0]  acc_q;

	logic [DW:0]       top;
	logic [DW:0]       diff;
	logic              qbit;
	logic [DW-1:0]     rem_next;

	always_comb begin
		top      = {acc_q[DW+NW-1:NW], acc_q[NW-1]};
		diff     = top - {1'b0, div_q};
		qbit     = (top >= {1'b0, div_q});
		rem_next = qbit ? diff[DW-1:0] : top[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= {{DW{1'b0}}, dividend};
			div_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {rem_next, acc_q[NW-2:0], qbit};
		end
	end

	assign status.done     = done_q;
	assign status.rem_zero = (acc_q[DW+NW-1:NW] == '0);
	assign quotient        = acc_q[NW-1:0];

endmodule

// ===== sv/semiprime_trial_division.sv =====
// Top level: semiprime test by wheel trial division over a bit-serial divider.
//
// Input channel (s_*): one item carries the number to test. s_tready is high
// only while the block is idle; one number is worked on at a time.
// Output channel (m_*): one result item per input item: found flag, smaller
// and larger prime factor (both zero when not found).
// Candidates d run 2, 3, 5, 7, 11, 13, ... (6k-1/6k+1 wheel) while d*d <= n.
// The first d that divides n is its smallest prime factor p; the quotient
// m = n/p is then tested for primality with the same candidate run picking up
// at p. d*d is kept as a running square, updated by shift and add. Each
// candidate is tried by the bit-serial divider (one quotient bit per cycle).
// A result is held in an output register with m_tvalid high until m_tready;
// the block stalls there and takes no new item until it is taken.
// Reset (arst_n low, asynchronous) returns to idle and drops m_tvalid.
module semiprime_trial_division #(
	parameter int NUMBER_WIDTH = 31
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// [NUMBER_WIDTH-1:0] number, rest zero
	input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]      s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// [0] found, [16:1] small_factor, [46:17] large_factor, [47] zero
	output logic [spt_pkg::OUT_TDATA_W-1:0]        m_tdata
);
	import spt_pkg::*;

	localparam int NW = NUMBER_WIDTH;
	localparam int DW = (NW + 1) / 2 + 1;   // candidate width, room past sqrt
	localparam int SW = 2 * DW;             // running square width

	state_t              state_q;
	wheel_t              wheel_q;
	logic                phase_q;           // 0: find smallest factor, 1: test quotient
	logic [NW-1:0]       num_q;
	logic [DW-1:0]       cand_q;
	logic [SW-1:0]       sq_q;
	logic [DW-1:0]       p_q;
	logic                found_q;
	logic [SMALL_W-1:0]  small_q;
	logic [LARGE_W-1:0]  large_q;

	logic                past_root;
	logic                div_start;
	div_status_t         div_st;
	logic [NW-1:0]       quot;
	logic [SW-1:0]       cand_ext;
	logic [DW-1:0]       cand_next;
	logic [SW-1:0]       sq_next;
	wheel_t              wheel_next;
	logic [SMALL_W+DW-1:0] small_ext;
	logic [LARGE_W+NW-1:0] large_ext;

	assign past_root = (sq_q > {{(SW - NW){1'b0}}, num_q});
	assign div_start = (state_q == ST_CHECK) && !past_root;
	assign cand_ext  = {{DW{1'b0}}, cand_q};
	assign small_ext = {{SMALL_W{1'b0}}, p_q};
	assign large_ext = {{LARGE_W{1'b0}}, num_q};

	// next wheel candidate; (d+s)^2 = d^2 + 2sd + s^2
	always_comb begin
		case (wheel_q)
			WH_TWO: begin
				cand_next  = cand_q + DW'(1);
				sq_next    = sq_q + (cand_ext << 1) + SW'(1);
				wheel_next = WH_THREE;
			end
			WH_THREE, WH_P2: begin
				cand_next  = cand_q + DW'(2);
				sq_next    = sq_q + (cand_ext << 2) + SW'(4);
				wheel_next = (wheel_q == WH_THREE) ? WH_P2 : WH_P4;
			end
			default: begin
				cand_next  = cand_q + DW'(4);
				sq_next    = sq_q + (cand_ext << 3) + SW'(16);
				wheel_next = WH_P2;
			end
		endcase
	end

	spt_serial_div #(
		.NW (NW),
		.DW (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_q),
		.divisor  (cand_q),
		.status   (div_st),
		.quotient (quot)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wheel_q <= WH_TWO;
			phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
						wheel_q <= WH_TWO;
						phase_q <= 1'b0;
					end
				end
				ST_CHECK: begin
					state_q <= past_root ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					if (div_st.done) begin
						if (div_st.rem_zero) begin
							phase_q <= 1'b1;
							state_q <= phase_q ? ST_OUT : ST_CHECK;
						end else begin
							wheel_q <= wheel_next;
							state_q <= ST_CHECK;
						end
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				num_q  <= s_tdata[NW-1:0];
				cand_q <= DW'(2);
				sq_q   <= SW'(4);
			end
			ST_CHECK: begin
				if (past_root) begin
					// no divisor left: n prime (not found) or quotient prime (found)
					found_q <= phase_q;
					small_q <= phase_q ? small_ext[SMALL_W-1:0] : '0;
					large_q <= phase_q ? large_ext[LARGE_W-1:0] : '0;
				end
			end
			ST_DIV: begin
				if (div_st.done) begin
					if (div_st.rem_zero) begin
						if (phase_q) begin
							// quotient composite: three or more prime factors
							found_q <= 1'b0;
							small_q <= '0;
							large_q <= '0;
						end else begin
							p_q   <= cand_q;
							num_q <= quot;
						end
					end else begin
						cand_q <= cand_next;
						sq_q   <= sq_next;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {1'b0, large_q, small_q, found_q};

endmodule

// ===== sv/spt_checker.sv =====
// Port-level checks for the semiprime block, bound to the top level.
module spt_checker #(
	parameter int NUMBER_WIDTH = 31
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic [((NUMBER_WIDTH+7)/8)*8-1:0]   s_tdata,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [spt_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import spt_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item in flight: no intake while a result is pending
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while result pending");

	// not found carries zero factors
	a_zero_factors: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[46:1] == '0)
		else $error("nonzero factors without found");

	// found carries a nonzero smaller factor
	a_small_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[16:1] != '0)
		else $error("found with zero small factor");

	// an accepted number closes the input right after the accept
	a_intake_closed: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input reopened right after accept");

endmodule

bind semiprime_trial_division spt_checker #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_spt_checker (.*);

// ===== verif/semiprime_trial_division_tb.sv =====
// Testbench for the semiprime trial-division block: directed table, random numbers, self-checked.
module semiprime_trial_division_tb;
	import spt_pkg::*;

	typedef struct packed {
		logic [LARGE_W-1:0] large_factor;
		logic [SMALL_W-1:0] small_factor;
		logic               found;
	} factor_result_t;

	typedef struct {
		bit             typed;
		factor_result_t answer;
	} factor_tag_t;

	typedef struct {
		logic [30:0]        number;
		bit                 typed;
		logic               found;
		logic [SMALL_W-1:0] small_factor;
		logic [LARGE_W-1:0] large_factor;
	} number_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [31:0]            s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	factor_tag_t    given_answers[$];
	factor_result_t awaited_results[$];
	int             errors = 0;
	bit             quiet = 1'b0;

	// typed rows carry answers that are obvious; the rest go through the predictor
	number_row_t directed_rows[22] = '{
		'{0,          1, 0, 0, 0},
		'{1,          1, 0, 0, 0},
		'{2,          1, 0, 0, 0},
		'{3,          1, 0, 0, 0},
		'{4,          1, 1, 2, 2},
		'{6,          1, 1, 2, 3},
		'{8,          1, 0, 0, 0},
		'{9,          1, 1, 3, 3},
		'{12,         1, 0, 0, 0},
		'{25,         1, 1, 5, 5},
		'{35,         1, 1, 5, 7},
		'{49,         1, 1, 7, 7},
		'{30,         1, 0, 0, 0},
		'{77,         0, 0, 0, 0},
		'{121,        0, 0, 0, 0},
		'{143,        0, 0, 0, 0},
		'{2000006,    0, 0, 0, 0},
		'{1073741824, 1, 0, 0, 0},
		'{715827882,  0, 0, 0, 0},
		'{1431655765, 0, 0, 0, 0},
		'{2147483646, 0, 0, 0, 0},
		'{2147483647, 0, 0, 0, 0}
	};

	semiprime_trial_division i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic bit is_prime(input longint unsigned v);
		longint unsigned d;
		longint unsigned step;
		if (v == 2 || v == 3 || v == 5 || v == 7)
			return 1'b1;
		if (v % 2 == 0 || v % 3 == 0 || v % 5 == 0 || v % 7 == 0)
			return 1'b0;
		step = 4;
		// 6k+-1 wheel from 11
		for (d = 11; d * d <= v; d += step) begin
			if (v % d == 0)
				return 1'b0;
			step = 6 - step;
		end
		return 1'b1;
	endfunction

	function automatic factor_result_t factor_semiprime(input logic [30:0] number);
		longint unsigned n;
		longint unsigned i;
		longint unsigned q;
		factor_result_t r;
		n = 64'(number);
		r = '0;
		for (i = 2; i * i <= n; i++) begin
			q = n / i;
			if (n % i == 0 && is_prime(i) && is_prime(q)) begin
				r.found = 1'b1;
				r.small_factor = i[SMALL_W-1:0];
				r.large_factor = q[LARGE_W-1:0];
				return r;
			end
		end
		return r;
	endfunction

	function automatic int idle_cycles();
		return quiet ? 0 : $urandom_range(0, 6);
	endfunction

	task automatic offer_number(input logic [30:0] number, input bit typed,
			input factor_result_t answer);
		int gap;
		factor_tag_t tag;
		gap = idle_cycles();
		tag.typed = typed;
		tag.answer = answer;
		given_answers.push_back(tag);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, number};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0 || given_answers.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : check_results
		factor_tag_t tag;
		factor_result_t want;
		factor_result_t got;
		if (s_tvalid && s_tready && given_answers.size() != 0) begin
			tag = given_answers.pop_front();
			want = tag.typed ? tag.answer : factor_semiprime(s_tdata[30:0]);
			awaited_results.push_back(want);
		end
		if (m_tvalid && m_tready) begin
			got = m_tdata[LARGE_W+SMALL_W:0];
			if (awaited_results.size() == 0) begin
				$error("result with nothing awaited: %h", m_tdata);
				errors++;
			end else begin
				want = awaited_results.pop_front();
				if (got.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, got.found);
					errors++;
				end
				if (got.small_factor !== want.small_factor) begin
					$error("small_factor: expected %0d, got %0d",
						want.small_factor, got.small_factor);
					errors++;
				end
				if (got.large_factor !== want.large_factor) begin
					$error("large_factor: expected %0d, got %0d",
						want.large_factor, got.large_factor);
					errors++;
				end
			end
		end
	end

	// receiver: stalls land while a result is already held
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = idle_cycles();
			if (stall > 0) begin
				m_tready <= 1'b0;
				do @(posedge clk); while (!m_tvalid);
				repeat (stall - 1) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin : stimulus
		logic [30:0] n;
		int unsigned pick;
		int unsigned p;
		int unsigned q;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r])
			offer_number(directed_rows[r].number, directed_rows[r].typed,
				{directed_rows[r].large_factor, directed_rows[r].small_factor,
				directed_rows[r].found});
		drain_results();

		for (int k = 0; k < 100; k++) begin
			quiet = ((k / 20) % 3) == 1;
			if (k == 50)
				drain_results();
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				n = 31'($urandom_range(0, 4095));
			end else if (pick < 65) begin
				// built semiprime, small enough to stay quick
				do p = $urandom_range(2, 255); while (!is_prime(64'(p)));
				do q = $urandom_range(2, 2047); while (!is_prime(64'(q)));
				n = 31'(p * q);
			end else if (pick < 75) begin
				n = 31'($urandom_range(0, 262143));
			end else if (pick < 90) begin
				// wide numbers with 2 at least twice as a factor: cheap for the block
				n = 31'($urandom_range(0, 32'h7FFFFFFF));
				n[1:0] = 2'b00;
			end else begin
				n = 31'($urandom_range(0, 238609294) * 9);
			end
			offer_number(n, 1'b0, '0);
		end

		drain_results();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin : watchdog
		#200_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
